>>> src/line_segment_rect_clip_macros.svh
// Assertion helpers shared by the checker.
`ifndef LINE_SEGMENT_RECT_CLIP_MACROS_SVH
`define LINE_SEGMENT_RECT_CLIP_MACROS_SVH

// Implication check, disabled during reset.
`define LSRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, disabled during reset.
`define LSRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Plain check on every edge.
`define LSRC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

>>> src/lsrc_pkg.sv
package lsrc_pkg;

  localparam int CW         = 16;
  localparam int EW         = ((2 * CW > 41) ? 2 * CW : 41) + 2;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (2 * CW) / DIV_STEPS;
  localparam int LERP_LAT   = DIV_STAGES + 3;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } clip_t;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } cfg_reg_e;

endpackage

>>> src/lsrc_lerp.sv
module lsrc_lerp (
  input  logic            clk,
  input  logic            en,
  input  lsrc_pkg::coord_t a0,
  input  lsrc_pkg::coord_t b0,
  input  lsrc_pkg::coord_t a1,
  input  lsrc_pkg::coord_t b1,
  input  lsrc_pkg::coord_t t,
  output lsrc_pkg::coord_t q
);
  import lsrc_pkg::*;

  localparam logic [EW-1:0] QCAP = EW'(64'd1 << 40);

  typedef struct packed {
    logic [CW-1:0]   rem;
    logic [2*CW-1:0] nq;
    logic [CW-1:0]   d;
    logic            neg;
    logic            zero;
    coord_t          b0;
  } dstage_t;

  typedef struct packed {
    logic [CW-1:0] mdv;
    logic [CW-1:0] mn;
    logic [CW-1:0] md;
    logic          neg;
    logic          zero;
    coord_t        b0;
  } front_t;

  function automatic dstage_t div_step(dstage_t s);
    dstage_t       o;
    logic [CW:0]   tr;
    o = s;
    tr = {s.rem, s.nq[2*CW-1]};
    o.nq = {s.nq[2*CW-2:0], 1'b0};
    if (tr >= {1'b0, s.d}) begin
      tr = tr - {1'b0, s.d};
      o.nq[0] = 1'b1;
    end
    o.rem = tr[CW-1:0];
    return o;
  endfunction

  function automatic dstage_t div_multi(dstage_t s);
    dstage_t o;
    o = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      o = div_step(o);
    end
    return o;
  endfunction

  // operand prep
  logic signed [CW:0] d, n, dv, dm, nn, nneg, dvneg;
  front_t             fr_next, fr;

  always_comb begin
    d  = {a1[CW-1], a1} - {a0[CW-1], a0};
    n  = {t[CW-1], t} - {a0[CW-1], a0};
    dv = {b1[CW-1], b1} - {b0[CW-1], b0};
    if (d[CW]) begin
      dm = -d;
      nn = -n;
    end else begin
      dm = d;
      nn = n;
    end
    nneg  = -nn;
    dvneg = -dv;
    fr_next.md   = dm[CW-1:0];
    fr_next.mn   = nn[CW] ? nneg[CW-1:0] : nn[CW-1:0];
    fr_next.mdv  = dv[CW] ? dvneg[CW-1:0] : dv[CW-1:0];
    fr_next.neg  = dv[CW] != nn[CW];
    fr_next.zero = (d == '0);
    fr_next.b0   = b0;
  end

  dstage_t dp [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      fr <= fr_next;
      dp[0].rem  <= '0;
      dp[0].nq   <= fr.mdv * fr.mn;
      dp[0].d    <= fr.md;
      dp[0].neg  <= fr.neg;
      dp[0].zero <= fr.zero;
      dp[0].b0   <= fr.b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dp[k+1] <= div_multi(dp[k]);
      end
    end
  end

  // cap, sign, truncate toward zero
  dstage_t              dl;
  logic [EW-1:0]        qz, qc;
  logic signed [EW-1:0] base;
  coord_t               q_next;

  always_comb begin
    dl   = dp[DIV_STAGES];
    qz   = EW'(dl.nq);
    qc   = (qz > QCAP) ? QCAP : qz;
    base = {{(EW-CW){dl.b0[CW-1]}}, dl.b0};
    if (!dl.neg) begin
      base = base + $signed(qc);
      if (dl.rem != '0 && base < 0) base = base + 1;
    end else begin
      base = base - $signed(qc);
      if (dl.rem != '0 && base > 0) base = base - 1;
    end
    q_next = dl.zero ? dl.b0 : base[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

>>> src/line_segment_rect_clip.sv
// Throughput: one segment per cycle unless the output stalls; the chained x and y
// interpolation units (multiply, then a restoring divider at two quotient bits
// per stage) set depth. A stalled output holds the whole pipeline.
// Reset: synchronous; clears valid bits and loads the rectangle 0..1023.
module line_segment_rect_clip (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lsrc_pkg::seg_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lsrc_pkg::clip_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  lsrc_pkg::coord_t cfg_data
);
  import lsrc_pkg::*;

  typedef struct packed {
    logic   v;
    logic   rej;
    logic   interior;
    logic   fwd;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } ctxb_t;

  typedef struct packed {
    ctxb_t  c;
    logic   ok;
    coord_t px1;
    coord_t py1;
    coord_t px2;
    coord_t py2;
  } ctxd_t;

  typedef struct packed {
    ctxd_t  c;
    coord_t t1;
    coord_t t2;
    logic   u1;
    logic   u2;
    logic   oky;
  } ctxy_t;

  coord_t win_left, win_right, win_bottom, win_top;
  logic   en;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= CW'(0);
      win_right  <= CW'(1023);
      win_bottom <= CW'(0);
      win_top    <= CW'(1023);
    end else if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        REG_LEFT:   win_left   <= cfg_data;
        REG_RIGHT:  win_right  <= cfg_data;
        REG_BOTTOM: win_bottom <= cfg_data;
        REG_TOP:    win_top    <= cfg_data;
        default:    win_left   <= win_left;
      endcase
    end
  end

  // stage A: trivial reject / accept, order by x
  logic  in_v;
  seg_t  in_r;
  ctxb_t ctxb_next, ctxb;

  always_comb begin
    coord_t x1, y1, x2, y2;
    x1 = in_r.start_x;
    y1 = in_r.start_y;
    x2 = in_r.end_x;
    y2 = in_r.end_y;
    ctxb_next.v   = in_v;
    ctxb_next.rej = (x1 <= win_left && x2 <= win_left) ||
                    (x1 >= win_right && x2 >= win_right) ||
                    (y1 <= win_bottom && y2 <= win_bottom) ||
                    (y1 >= win_top && y2 >= win_top);
    ctxb_next.interior = x1 > win_left && x1 < win_right && x2 > win_left &&
                         x2 < win_right && y1 > win_bottom && y1 < win_top &&
                         y2 > win_bottom && y2 < win_top;
    ctxb_next.fwd = x1 < x2;
    if (ctxb_next.fwd) begin
      ctxb_next.ax = x1; ctxb_next.ay = y1; ctxb_next.bx = x2; ctxb_next.by = y2;
    end else begin
      ctxb_next.ax = x2; ctxb_next.ay = y2; ctxb_next.bx = x1; ctxb_next.by = y1;
    end
  end

  // x interpolation
  coord_t lx1, lx2;
  ctxb_t  xline [LERP_LAT];

  lsrc_lerp u_lerp_x1 (
    .clk(clk), .en(en), .a0(ctxb.ax), .b0(ctxb.ay), .a1(ctxb.bx), .b1(ctxb.by),
    .t(win_left), .q(lx1)
  );
  lsrc_lerp u_lerp_x2 (
    .clk(clk), .en(en), .a0(ctxb.ax), .b0(ctxb.ay), .a1(ctxb.bx), .b1(ctxb.by),
    .t(win_right), .q(lx2)
  );

  // stage C: x clip
  ctxd_t ctxd_next, ctxd;

  always_comb begin
    ctxb_t c;
    c = xline[LERP_LAT-1];
    ctxd_next.c   = c;
    ctxd_next.ok  = 1'b1;
    ctxd_next.px1 = c.ax;
    ctxd_next.py1 = c.ay;
    ctxd_next.px2 = c.bx;
    ctxd_next.py2 = c.by;
    if (!c.interior) begin
      if (c.ax < win_left) begin
        ctxd_next.px1 = win_left;
        ctxd_next.py1 = lx1;
        if (c.bx > win_right) begin
          ctxd_next.px2 = win_right;
          ctxd_next.py2 = lx2;
        end
      end else if (c.ax < win_right) begin
        if (c.bx > win_right) begin
          ctxd_next.px2 = win_right;
          ctxd_next.py2 = lx2;
        end
      end else begin
        ctxd_next.ok = 1'b0;
      end
    end
  end

  // stage D: y edge choice
  ctxy_t ctxy_next;

  always_comb begin
    ctxy_next.c   = ctxd;
    ctxy_next.t1  = (ctxd.py1 < win_bottom) ? win_bottom : win_top;
    ctxy_next.t2  = (ctxd.py2 > win_top) ? win_top : win_bottom;
    ctxy_next.u1  = 1'b0;
    ctxy_next.u2  = 1'b0;
    ctxy_next.oky = 1'b1;
    if (!ctxd.c.interior) begin
      if (ctxd.py1 < win_bottom) begin
        if (ctxd.py2 > win_top) begin
          ctxy_next.u1 = 1'b1;
          ctxy_next.u2 = 1'b1;
        end else if (ctxd.py2 > win_bottom) begin
          ctxy_next.u1 = 1'b1;
        end else begin
          ctxy_next.oky = 1'b0;
        end
      end else if (ctxd.py1 < win_top) begin
        if (ctxd.py2 > win_top || ctxd.py2 < win_bottom) begin
          ctxy_next.u2 = 1'b1;
        end
      end else begin
        if (ctxd.py2 < win_bottom) begin
          ctxy_next.u1 = 1'b1;
          ctxy_next.u2 = 1'b1;
        end else if (ctxd.py2 < win_top) begin
          ctxy_next.u1 = 1'b1;
        end else begin
          ctxy_next.oky = 1'b0;
        end
      end
    end
  end

  coord_t ly1, ly2;
  ctxy_t  yline [LERP_LAT];

  lsrc_lerp u_lerp_y1 (
    .clk(clk), .en(en), .a0(ctxd.c.ay), .b0(ctxd.c.ax), .a1(ctxd.c.by),
    .b1(ctxd.c.bx), .t(ctxy_next.t1), .q(ly1)
  );
  lsrc_lerp u_lerp_y2 (
    .clk(clk), .en(en), .a0(ctxd.c.ay), .b0(ctxd.c.ax), .a1(ctxd.c.by),
    .b1(ctxd.c.bx), .t(ctxy_next.t2), .q(ly2)
  );

  // stage F: y clip, restore input order
  clip_t out_next;

  always_comb begin
    ctxy_t  y;
    coord_t qx1, qy1, qx2, qy2;
    logic   vis;
    y   = yline[LERP_LAT-1];
    qx1 = y.u1 ? ly1 : y.c.px1;
    qy1 = y.u1 ? y.t1 : y.c.py1;
    qx2 = y.u2 ? ly2 : y.c.px2;
    qy2 = y.u2 ? y.t2 : y.c.py2;
    vis = !y.c.c.rej && (y.c.c.interior || (y.c.ok && y.oky));
    out_next.visible = vis;
    if (!vis) begin
      out_next.clip_start_x = '0;
      out_next.clip_start_y = '0;
      out_next.clip_end_x   = '0;
      out_next.clip_end_y   = '0;
    end else if (y.c.c.fwd) begin
      out_next.clip_start_x = qx1;
      out_next.clip_start_y = qy1;
      out_next.clip_end_x   = qx2;
      out_next.clip_end_y   = qy2;
    end else begin
      out_next.clip_start_x = qx2;
      out_next.clip_start_y = qy2;
      out_next.clip_end_x   = qx1;
      out_next.clip_end_y   = qy1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v      <= 1'b0;
      ctxb.v    <= 1'b0;
      ctxd.c.v  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < LERP_LAT; i++) begin
        xline[i].v   <= 1'b0;
        yline[i].c.c.v <= 1'b0;
      end
    end else if (en) begin
      in_v      <= in_valid;
      in_r      <= in_data;
      ctxb      <= ctxb_next;
      ctxd      <= ctxd_next;
      xline[0]  <= ctxb;
      yline[0]  <= ctxy_next;
      for (int i = 1; i < LERP_LAT; i++) begin
        xline[i] <= xline[i-1];
        yline[i] <= yline[i-1];
      end
      out_valid <= yline[LERP_LAT-1].c.c.v;
      out_data  <= out_next;
    end
  end

endmodule

>>> src/lsrc_checker.sv
`include "line_segment_rect_clip_macros.svh"

module lsrc_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input lsrc_pkg::seg_t   in_data,
  input logic             out_valid,
  input logic             out_ready,
  input lsrc_pkg::clip_t  out_data,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [1:0]       cfg_index,
  input lsrc_pkg::coord_t cfg_data
);
  import lsrc_pkg::*;

  `LSRC_ASSERT_IMPL(a_rdy_follows_out, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not track output stall")
  `LSRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `LSRC_ASSERT_IMPL(a_reject_zero, out_valid && !out_data.visible, out_data.clip_start_x == '0 && out_data.clip_start_y == '0 && out_data.clip_end_x == '0 && out_data.clip_end_y == '0, "rejected segment has nonzero coordinates")
  `LSRC_ASSERT_ALWAYS(a_reset_empty, rst || !$past(rst) || !out_valid, "result valid right after reset")

endmodule

bind line_segment_rect_clip lsrc_checker u_lsrc_checker (.*);

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lsrc_pkg::*;

  class clip_scoreboard;
    longint win_l, win_r, win_b, win_t;
    clip_t  expected_q[$];
    int     mismatches;

    function new();
      win_l = 0; win_r = 1023; win_b = 0; win_t = 1023;
      mismatches = 0;
    endfunction

    function void set_edge(cfg_reg_e idx, coord_t v);
      case (idx)
        REG_LEFT:   win_l = v;
        REG_RIGHT:  win_r = v;
        REG_BOTTOM: win_b = v;
        REG_TOP:    win_t = v;
        default:    win_l = win_l;
      endcase
    endfunction

    // exact interpolation, truncated toward zero
    function longint interp(longint a0, longint b0, longint a1, longint b1, longint t);
      longint d, n, dv, p, q, r, base;
      bit neg;
      d = a1 - a0; n = t - a0; dv = b1 - b0;
      if (d == 0) return b0;
      if (d < 0) begin
        d = -d; n = -n;
      end
      neg = (dv < 0) != (n < 0);
      p = (dv < 0 ? -dv : dv) * (n < 0 ? -n : n);
      q = p / d; r = p % d;
      if (!neg) begin
        base = b0 + q;
        if (r != 0 && base < 0) base += 1;
      end else begin
        base = b0 - q;
        if (r != 0 && base > 0) base -= 1;
      end
      return base;
    endfunction

    function clip_t clip_segment(seg_t s);
      longint x1, y1, x2, y2, ax, ay, bx, by, px1, py1, px2, py2;
      bit fwd, ok;
      clip_t c;
      c = '0; ok = 1;
      x1 = s.start_x; y1 = s.start_y; x2 = s.end_x; y2 = s.end_y;
      if ((x1 <= win_l && x2 <= win_l) || (x1 >= win_r && x2 >= win_r) ||
          (y1 <= win_b && y2 <= win_b) || (y1 >= win_t && y2 >= win_t))
        return c;
      if (x1 > win_l && x1 < win_r && x2 > win_l && x2 < win_r &&
          y1 > win_b && y1 < win_t && y2 > win_b && y2 < win_t) begin
        px1 = x1; py1 = y1; px2 = x2; py2 = y2; fwd = 1;
      end else begin
        fwd = x1 < x2;
        if (fwd) begin
          ax = x1; ay = y1; bx = x2; by = y2;
        end else begin
          ax = x2; ay = y2; bx = x1; by = y1;
        end
        px1 = ax; py1 = ay; px2 = bx; py2 = by;
        if (px1 < win_l) begin
          px1 = win_l; py1 = interp(ax, ay, bx, by, win_l);
          if (px2 > win_r) begin
            px2 = win_r; py2 = interp(ax, ay, bx, by, win_r);
          end
        end else if (px1 < win_r) begin
          if (px2 > win_r) begin
            px2 = win_r; py2 = interp(ax, ay, bx, by, win_r);
          end
        end else ok = 0;
        if (ok) begin
          if (py1 < win_b) begin
            if (py2 > win_t) begin
              px1 = interp(ay, ax, by, bx, win_b); py1 = win_b;
              px2 = interp(ay, ax, by, bx, win_t); py2 = win_t;
            end else if (py2 > win_b) begin
              px1 = interp(ay, ax, by, bx, win_b); py1 = win_b;
            end else ok = 0;
          end else if (py1 < win_t) begin
            if (py2 > win_t) begin
              px2 = interp(ay, ax, by, bx, win_t); py2 = win_t;
            end else if (py2 < win_b) begin
              px2 = interp(ay, ax, by, bx, win_b); py2 = win_b;
            end
          end else begin
            if (py2 < win_b) begin
              px1 = interp(ay, ax, by, bx, win_t); py1 = win_t;
              px2 = interp(ay, ax, by, bx, win_b); py2 = win_b;
            end else if (py2 < win_t) begin
              px1 = interp(ay, ax, by, bx, win_t); py1 = win_t;
            end else ok = 0;
          end
        end
        if (!ok) return c;
      end
      c.visible = 1'b1;
      if (fwd) begin
        c.clip_start_x = coord_t'(px1); c.clip_start_y = coord_t'(py1);
        c.clip_end_x = coord_t'(px2); c.clip_end_y = coord_t'(py2);
      end else begin
        c.clip_start_x = coord_t'(px2); c.clip_start_y = coord_t'(py2);
        c.clip_end_x = coord_t'(px1); c.clip_end_y = coord_t'(py1);
      end
      return c;
    endfunction

    function void note_segment(seg_t s);
      expected_q.push_back(clip_segment(s));
    endfunction

    function void check_clip(clip_t got);
      clip_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.visible !== e.visible || got.clip_start_x !== e.clip_start_x ||
          got.clip_start_y !== e.clip_start_y || got.clip_end_x !== e.clip_end_x ||
          got.clip_end_y !== e.clip_end_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp vis=%0d (%0d,%0d)-(%0d,%0d) got vis=%0d (%0d,%0d)-(%0d,%0d)",
                   e.visible, e.clip_start_x, e.clip_start_y, e.clip_end_x, e.clip_end_y,
                   got.visible, got.clip_start_x, got.clip_start_y, got.clip_end_x,
                   got.clip_end_y);
      end
    endfunction
  endclass

  logic   clk = 0, rst = 1;
  logic   in_valid = 0, in_ready, out_valid, out_ready = 0;
  seg_t   in_data = '0;
  clip_t  out_data;
  logic   cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = '0;
  coord_t cfg_data = '0;

  clip_scoreboard sb = new();
  int send_idle_pct = 0, recv_idle_pct = 0;
  int quiet_cycles = 0;

  line_segment_rect_clip DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_clip(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_segment(seg_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_segment(s);
  endtask

  task automatic seg(int x1, int y1, int x2, int y2);
    seg_t s;
    s.start_x = coord_t'(x1); s.start_y = coord_t'(y1);
    s.end_x = coord_t'(x2); s.end_y = coord_t'(y2);
    send_segment(s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_edge(cfg_reg_e idx, int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= coord_t'(v);
    do @(posedge clk); while (!cfg_ready);
    sb.set_edge(idx, coord_t'(v));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(int l, int r, int b, int t);
    drain();
    write_edge(REG_LEFT, l);
    write_edge(REG_RIGHT, r);
    write_edge(REG_BOTTOM, b);
    write_edge(REG_TOP, t);
  endtask

  function automatic int near_coord(longint lo, longint hi);
    longint a, b, v;
    if ($urandom_range(3) == 0) return $signed(16'($urandom));
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    v = a - 64 + longint'($urandom_range(int'(b - a + 128)));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return int'(v);
  endfunction

  task automatic random_segments(int n);
    repeat (n)
      seg(near_coord(sb.win_l, sb.win_r), near_coord(sb.win_b, sb.win_t),
          near_coord(sb.win_l, sb.win_r), near_coord(sb.win_b, sb.win_t));
  endtask

  initial begin
    int l, r, b, t;
    send_idle_pct = 29; recv_idle_pct = 67;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed, reset window 0..1023
    seg(100, 200, 900, 800);
    seg(-5, 100, 0, 900);
    seg(1023, 10, 2000, 500);
    seg(10, -100, 500, 0);
    seg(10, 1023, 500, 1500);
    seg(-100, 500, 500, 600);
    seg(500, 600, -100, 500);
    seg(-300, 100, 1500, 900);
    seg(300, -200, 700, 1400);
    seg(700, 1400, 300, -200);
    seg(-500, -500, 1500, 1500);
    seg(1500, -500, -500, 1500);
    seg(400, -50, 400, 1100);
    seg(400, 1100, 400, -50);
    seg(0, 500, 1023, 500);
    seg(-32768, -32768, 32767, 32767);
    seg(32767, -32768, -32768, 32767);
    seg(-32768, 500, 32767, 510);
    seg(500, 500, 500, 500);
    seg(-10, 1200, 1200, -10);
    random_segments(180);
    set_window(-32768, 32767, -32768, 32767);
    seg(-32768, 0, 32767, 5);
    seg(-32767, -32767, 32766, 32766);
    random_segments(200);
    send_idle_pct = 67; recv_idle_pct = 29;
    set_window(500, -500, 300, -300);
    random_segments(150);
    set_window(10, 12, 10, 12);
    seg(11, 11, 11, 11);
    random_segments(200);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int k = 0; k < 5; k++) begin
      l = $signed(16'($urandom)); r = $signed(16'($urandom));
      b = $signed(16'($urandom)); t = $signed(16'($urandom));
      if (k != 4) begin
        if (l > r) begin l = l ^ r; r = l ^ r; l = l ^ r; end
        if (b > t) begin b = b ^ t; t = b ^ t; b = b ^ t; end
      end
      set_window(l, r, b, t);
      random_segments(110);
    end
    drain();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/lsrc_pkg.sv
src/lsrc_lerp.sv
src/line_segment_rect_clip.sv
src/lsrc_checker.sv
tb/tb_top.sv
